>>> src/nsm_pkg.sv
// nsm_pkg: shared constants, codes and types of the naive substring matcher
// used by nsm_match, nsm_track and naive_substring_matcher_core; no dependencies

package nsm_pkg;

	// pattern storage
	localparam int MAX_PATTERN = 16;
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 5;
	localparam int SLOT_W      = $clog2(MAX_PATTERN);
	localparam int PAT_W       = MAX_PATTERN * CHAR_W;
	localparam int REG_W       = 64;

	// text positions
	localparam int MAX_TEXT  = 65536;
	localparam int POS_W     = 16;
	localparam int POS_LIMIT = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;
	localparam int CNT_W     = $clog2(POS_LIMIT + 1);

	// configuration register indexes
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_PAT_LEN  = 2'd0;
	localparam logic [IDX_W-1:0] REG_PAT_LOW  = 2'd1;
	localparam logic [IDX_W-1:0] REG_PAT_HIGH = 2'd2;

	// result tdata: 37 bits of fields padded to 40
	localparam int OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_NO_MATCH  = 2'd2
	} status_t;

	// one byte moving from the input register into the result register
	typedef struct packed {
		logic adv;
		logic last;
		logic eq;
	} step_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] hit_position;
		logic             hit_is_first;
		logic             text_end;
		status_t          search_status;
		logic [POS_W-1:0] first_position;
		logic             position_overflow;
	} result_t;

endpackage

>>> src/nsm_match.sv
// nsm_match: window of the most recent text bytes and the parallel pattern compare
// depends on nsm_pkg

module nsm_match (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [nsm_pkg::CHAR_W-1:0]    text_char,
	input  logic [nsm_pkg::PAT_W-1:0]     pattern,
	input  logic [nsm_pkg::LEN_W-1:0]     eff_len,
	output logic                          eq
);

	logic [nsm_pkg::CHAR_W-1:0] window_q   [nsm_pkg::MAX_PATTERN];
	logic [nsm_pkg::CHAR_W-1:0] window_new [nsm_pkg::MAX_PATTERN];
	logic [nsm_pkg::SLOT_W-1:0] sel        [nsm_pkg::MAX_PATTERN];
	logic [nsm_pkg::MAX_PATTERN-1:0] slot_ok;

	// slot 0 holds the newest byte, the one arriving now
	always_comb begin
		window_new[0] = text_char;
		for (int j = 1; j < nsm_pkg::MAX_PATTERN; j++) begin
			window_new[j] = window_q[j-1];
		end
	end

	// pattern byte k sits len-1-k slots back; bytes beyond the length always agree
	always_comb begin
		for (int k = 0; k < nsm_pkg::MAX_PATTERN; k++) begin
			sel[k] = nsm_pkg::SLOT_W'(eff_len - nsm_pkg::LEN_W'(1) - nsm_pkg::LEN_W'(k));
			slot_ok[k] = (nsm_pkg::LEN_W'(k) >= eff_len) ||
				(window_new[sel[k]] ==
				 pattern[k*nsm_pkg::CHAR_W +: nsm_pkg::CHAR_W]);
		end
	end

	assign eq = &slot_ok;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < nsm_pkg::MAX_PATTERN; j++) begin
				window_q[j] <= window_new[j];
			end
		end
	end

endmodule

>>> src/nsm_track.sv
// nsm_track: per-text position count, first-hit tracking and result formation
// depends on nsm_pkg

module nsm_track (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nsm_pkg::step_t             step,
	input  logic [nsm_pkg::LEN_W-1:0]  eff_len,
	output nsm_pkg::result_t           res
);

	logic [nsm_pkg::CNT_W-1:0] count_q;
	logic                      found_q;
	logic [nsm_pkg::POS_W-1:0] first_q;
	logic                      ovf_q;

	logic                      at_limit;
	logic [nsm_pkg::POS_W-1:0] idx;
	logic [nsm_pkg::POS_W:0]   span;
	logic [nsm_pkg::POS_W-1:0] hpos;
	logic                      hit;
	logic                      is_first;
	logic [nsm_pkg::CNT_W-1:0] count_next;
	logic                      found_next;
	logic [nsm_pkg::POS_W-1:0] first_next;
	logic                      ovf_next;

	always_comb begin
		at_limit   = count_q >= nsm_pkg::CNT_W'(nsm_pkg::POS_LIMIT);
		idx        = at_limit ? nsm_pkg::POS_W'(nsm_pkg::POS_LIMIT - 1)
		                      : count_q[nsm_pkg::POS_W-1:0];
		count_next = at_limit ? count_q : count_q + nsm_pkg::CNT_W'(1);
		ovf_next   = ovf_q | at_limit;

		// bytes seen so far in this text, capped; a hit needs at least len of them
		span       = {1'b0, idx} + (nsm_pkg::POS_W+1)'(1);
		hit        = step.eq && (span >= (nsm_pkg::POS_W+1)'(eff_len));
		hpos       = nsm_pkg::POS_W'(span - (nsm_pkg::POS_W+1)'(eff_len));
		is_first   = hit && !found_q;
		found_next = found_q | hit;
		first_next = is_first ? hpos : first_q;

		res.hit               = hit;
		res.hit_position      = hit ? hpos : '0;
		res.hit_is_first      = is_first;
		res.text_end          = step.last;
		res.position_overflow = ovf_next;
		res.search_status     = nsm_pkg::ST_FOUND;
		res.first_position    = '0;
		if (step.last) begin
			if (found_next) begin
				res.first_position = first_next;
			end else if (count_next < nsm_pkg::CNT_W'(eff_len)) begin
				res.search_status = nsm_pkg::ST_TOO_SHORT;
			end else begin
				res.search_status = nsm_pkg::ST_NO_MATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
			first_q <= '0;
			ovf_q   <= 1'b0;
		end else if (step.adv) begin
			if (step.last) begin
				count_q <= '0;
				found_q <= 1'b0;
				first_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_next;
				found_q <= found_next;
				first_q <= first_next;
				ovf_q   <= ovf_next;
			end
		end
	end

endmodule

>>> src/naive_substring_matcher_core.sv
// Streaming substring matcher: one text byte per transaction on the slave side, tlast on the
// final byte of a text; one result per byte on the master side, in order. The block takes a
// byte every clock cycle while the master side keeps tready high: a byte goes into the input
// register, is compared in parallel against the configured pattern (up to 16 bytes) and its
// result is written to the output register once that register is empty or being emptied.
// Otherwise the byte waits in the input register. A hit is
// reported on the byte where an occurrence ends, overlapping ones included. The result for
// the tlast byte also carries the search status and the first match position, after which
// all per-text state clears. Positions saturate at 65535 and raise a sticky overflow flag.
// Write the pattern registers only while no text is in flight.
// depends on nsm_pkg, nsm_match, nsm_track

module naive_substring_matcher_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [nsm_pkg::IDX_W-1:0]         cfg_index,
	input  logic [nsm_pkg::REG_W-1:0]         cfg_wdata,
	// text bytes
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // text_char
	input  logic                              s_tlast,   // text_last
	// results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit, hit_position[16:1], hit_is_first, search_status[19:18],
	// first_position[35:20], position_overflow, zero padding[39:37]
	output logic [nsm_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast    // text_end
);

	logic [nsm_pkg::LEN_W-1:0]  pat_len_q;
	logic [nsm_pkg::REG_W-1:0]  pat_low_q;
	logic [nsm_pkg::REG_W-1:0]  pat_high_q;
	logic [nsm_pkg::LEN_W-1:0]  eff_len;

	logic                       valid_s1;
	logic [7:0]                 char_s1;
	logic                       last_s1;

	logic                       out_valid_q;
	nsm_pkg::result_t           out_q;

	logic                       adv;
	logic                       eq;
	nsm_pkg::step_t             step;
	nsm_pkg::result_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q  <= nsm_pkg::LEN_W'(1);
			pat_low_q  <= '0;
			pat_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				nsm_pkg::REG_PAT_LEN:  pat_len_q  <= cfg_wdata[nsm_pkg::LEN_W-1:0];
				nsm_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_wdata;
				nsm_pkg::REG_PAT_HIGH: pat_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// zero counts as one byte, anything beyond the window as the full window
	always_comb begin
		if (pat_len_q == '0) begin
			eff_len = nsm_pkg::LEN_W'(1);
		end else if (pat_len_q > nsm_pkg::LEN_W'(nsm_pkg::MAX_PATTERN)) begin
			eff_len = nsm_pkg::LEN_W'(nsm_pkg::MAX_PATTERN);
		end else begin
			eff_len = pat_len_q;
		end
	end

	// a byte moves on when the result register is empty or being emptied
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	nsm_match u_match (
		.clk       (clk),
		.adv       (adv),
		.text_char (char_s1),
		.pattern   ({pat_high_q, pat_low_q}),
		.eff_len   (eff_len),
		.eq        (eq)
	);

	always_comb begin
		step.adv  = adv;
		step.last = last_s1;
		step.eq   = eq;
	end

	nsm_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.eff_len (eff_len),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.text_end;
	assign m_tdata  = {3'b000,
	                   out_q.position_overflow,
	                   out_q.first_position,
	                   out_q.search_status,
	                   out_q.hit_is_first,
	                   out_q.hit_position,
	                   out_q.hit};

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench of naive_substring_matcher_core, driving text bytes and
// pattern registers, predicting every result in step and comparing it field by field
// depends on nsm_pkg and the naive_substring_matcher_core rtl

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [nsm_pkg::IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index
	localparam int HOLD_CYCLES = 48;
	localparam logic [nsm_pkg::CHAR_W-1:0] CH_A = "a";
	localparam logic [nsm_pkg::CHAR_W-1:0] CH_B = "b";

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [nsm_pkg::IDX_W-1:0]      cfg_index = '0;
	logic [nsm_pkg::REG_W-1:0]      cfg_wdata = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = '0;   // text_char
	logic                           s_tlast   = 1'b0; // text_last
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	// hit, hit_position[16:1], hit_is_first, search_status[19:18],
	// first_position[35:20], position_overflow, zero padding[39:37]
	logic [nsm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;          // text_end

	naive_substring_matcher_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// mirror of the registers and of the per-text state
	logic [nsm_pkg::LEN_W-1:0]  cfg_len     = 5'd1;
	logic [nsm_pkg::PAT_W-1:0]  cfg_pattern = '0;
	logic [nsm_pkg::CHAR_W-1:0] window [nsm_pkg::MAX_PATTERN];
	logic [nsm_pkg::CNT_W-1:0]  text_count;
	logic                       seen_hit;
	logic [nsm_pkg::POS_W-1:0]  first_hit;
	logic                       saw_overflow;

	nsm_pkg::result_t  scan_results [$];
	logic [7:0]        text_buf [$];
	bit                quiet      = 1'b0;
	int                hold_left  = 0;
	int                mismatches = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned used_length();
		int unsigned n;
		n = cfg_len;
		if (n == 0) n = 1;
		if (n > nsm_pkg::MAX_PATTERN) n = nsm_pkg::MAX_PATTERN;
		return n;
	endfunction

	function automatic void clear_text_state();
		for (int k = 0; k < nsm_pkg::MAX_PATTERN; k++) window[k] = '0;
		text_count   = '0;
		seen_hit     = 1'b0;
		first_hit    = '0;
		saw_overflow = 1'b0;
	endfunction

	function automatic nsm_pkg::result_t scan_byte(input logic [7:0] ch, input logic last);
		nsm_pkg::result_t r;
		int unsigned      len;
		int unsigned      idx;
		logic             eq;
		r   = '0;
		len = used_length();
		for (int k = nsm_pkg::MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
		window[0] = ch;
		// positions stop at the last index once the text outgrows the counter
		if (text_count >= nsm_pkg::POS_LIMIT) begin
			saw_overflow = 1'b1;
			idx = nsm_pkg::POS_LIMIT - 1;
		end else begin
			idx = text_count;
			text_count++;
		end
		if (idx + 1 >= len) begin
			eq = 1'b1;
			for (int k = 0; k < len; k++)
				if (window[len-1-k] != cfg_pattern[nsm_pkg::CHAR_W*k +: nsm_pkg::CHAR_W])
					eq = 1'b0;
			if (eq) begin
				r.hit = 1'b1;
				r.hit_position = nsm_pkg::POS_W'(idx + 1 - len);
				if (!seen_hit) begin
					r.hit_is_first = 1'b1;
					seen_hit = 1'b1;
					first_hit = r.hit_position;
				end
			end
		end
		r.text_end = last;
		r.search_status = nsm_pkg::ST_FOUND;
		r.position_overflow = saw_overflow;
		if (last) begin
			if (seen_hit)
				r.first_position = first_hit;
			else if (text_count < len)
				r.search_status = nsm_pkg::ST_TOO_SHORT;
			else
				r.search_status = nsm_pkg::ST_NO_MATCH;
			clear_text_state();
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	// result side: random or held-off tready, and the field by field check
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 9);
			end
		end
	end

	initial begin
		nsm_pkg::result_t due;
		nsm_pkg::result_t seen;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				seen.hit               = m_tdata[0];
				seen.hit_position      = m_tdata[16:1];
				seen.hit_is_first      = m_tdata[17];
				seen.search_status     = nsm_pkg::status_t'(m_tdata[19:18]);
				seen.first_position    = m_tdata[35:20];
				seen.position_overflow = m_tdata[36];
				seen.text_end          = m_tlast;
				if (scan_results.size() == 0) begin
					report("unexpected result", '0, 32'(m_tdata));
				end else begin
					due = scan_results.pop_front();
					if (seen.hit != due.hit)
						report("hit", 32'(due.hit), 32'(seen.hit));
					if (seen.hit_position != due.hit_position)
						report("hit_position", 32'(due.hit_position),
							32'(seen.hit_position));
					if (seen.hit_is_first != due.hit_is_first)
						report("hit_is_first", 32'(due.hit_is_first),
							32'(seen.hit_is_first));
					if (seen.text_end != due.text_end)
						report("text_end", 32'(due.text_end), 32'(seen.text_end));
					if (seen.search_status != due.search_status)
						report("search_status", 32'(due.search_status),
							32'(seen.search_status));
					if (seen.first_position != due.first_position)
						report("first_position", 32'(due.first_position),
							32'(seen.first_position));
					if (seen.position_overflow != due.position_overflow)
						report("position_overflow", 32'(due.position_overflow),
							32'(seen.position_overflow));
				end
			end
		end
	end

	// one text byte; tvalid stays high afterwards so back-to-back bytes need no toggle
	task automatic send_byte(input logic [7:0] ch, input logic last);
		if (!quiet && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		scan_results.push_back(scan_byte(ch, last));
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (scan_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nsm_pkg::IDX_W-1:0] idx,
	                         input logic [nsm_pkg::REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			nsm_pkg::REG_PAT_LEN:  cfg_len = val[nsm_pkg::LEN_W-1:0];
			nsm_pkg::REG_PAT_LOW:  cfg_pattern[nsm_pkg::REG_W-1:0] = val;
			nsm_pkg::REG_PAT_HIGH: cfg_pattern[nsm_pkg::PAT_W-1:nsm_pkg::REG_W] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// text made mostly of whole or damaged copies of the pattern and pattern bytes
	task automatic fill_text(input int n);
		int len;
		int pick;
		int cut;
		int bad;
		logic [7:0] b;
		text_buf.delete();
		len = used_length();
		while (text_buf.size() < n) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				bad = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : -1;
				cut = (len > 1 && $urandom_range(5) == 0) ? $urandom_range(1, len - 1) : len;
				for (int k = 0; k < cut; k++) begin
					b = cfg_pattern[nsm_pkg::CHAR_W*k +: nsm_pkg::CHAR_W];
					if (k == bad) b = b ^ 8'($urandom_range(1, 255));
					text_buf.push_back(b);
				end
			end else if (pick < 75) begin
				text_buf.push_back(
					cfg_pattern[nsm_pkg::CHAR_W*$urandom_range(len - 1) +: nsm_pkg::CHAR_W]);
			end else begin
				text_buf.push_back(8'($urandom_range(255)));
			end
		end
		while (text_buf.size() > n) void'(text_buf.pop_back());
	endtask

	task automatic test_reset_pattern();
		// reset pattern is one zero byte
		text_buf = '{8'h00, 8'hFF};
		send_text();
		wait_idle();
	endtask

	task automatic test_overlap();
		write_reg(nsm_pkg::REG_PAT_LEN, 64'd2);
		write_reg(nsm_pkg::REG_PAT_LOW, {48'd0, CH_A, CH_A});
		text_buf = '{CH_A, CH_A, CH_A};
		send_text();
		wait_idle();
	endtask

	task automatic test_short_text();
		write_reg(nsm_pkg::REG_PAT_LEN, 64'd4);
		write_reg(nsm_pkg::REG_PAT_LOW, {32'd0, "d", "c", CH_B, CH_A});
		text_buf = '{CH_A, CH_B};
		send_text();
		wait_idle();
	endtask

	task automatic test_length_clamp();
		logic [nsm_pkg::PAT_W-1:0] pat;
		// zero length acts as one byte
		write_reg(nsm_pkg::REG_PAT_LEN, 64'd0);
		text_buf = '{CH_A};
		send_text();
		wait_idle();
		// lengths above sixteen act as sixteen
		write_reg(nsm_pkg::REG_PAT_LEN, 64'd17);
		write_reg(nsm_pkg::REG_PAT_LEN, 64'd31);
		pat = {$urandom, $urandom, $urandom, $urandom};
		write_reg(nsm_pkg::REG_PAT_LOW, pat[nsm_pkg::REG_W-1:0]);
		write_reg(nsm_pkg::REG_PAT_HIGH, pat[nsm_pkg::PAT_W-1:nsm_pkg::REG_W]);
		write_reg(REG_SPARE, '1);
		text_buf.delete();
		for (int k = 0; k < nsm_pkg::MAX_PATTERN; k++)
			text_buf.push_back(pat[nsm_pkg::CHAR_W*k +: nsm_pkg::CHAR_W]);
		send_text();
		wait_idle();
	endtask

	task automatic test_output_hold();
		// results pile up while tready is held low, so the input stalls
		fill_text(60);
		hold_left = HOLD_CYCLES;
		send_text();
		wait_idle();
	endtask

	task automatic test_sender_pause();
		fill_text(24);
		for (int i = 0; i < text_buf.size(); i++) begin
			if (i == 12) wait_idle();
			send_byte(text_buf[i], i == text_buf.size() - 1);
		end
		wait_idle();
	endtask

	task automatic test_full_rate();
		quiet = 1'b1;
		fill_text(150);
		send_text();
		wait_idle();
		quiet = 1'b0;
	endtask

	task automatic test_random_texts();
		int sent;
		int len_raw;
		int mode;
		int n;
		logic [nsm_pkg::PAT_W-1:0] pat;
		logic [nsm_pkg::REG_W-1:0] wd;
		sent = 0;
		while (sent < 250) begin
			case ($urandom_range(19))
				0:       len_raw = 0;
				1:       len_raw = 1;
				2, 3:    len_raw = nsm_pkg::MAX_PATTERN;
				4:       len_raw = $urandom_range(nsm_pkg::MAX_PATTERN + 1, 31);
				5, 6, 7: len_raw = $urandom_range(5, nsm_pkg::MAX_PATTERN - 1);
				default: len_raw = $urandom_range(1, 4);
			endcase
			mode = $urandom_range(19);
			pat = {$urandom, $urandom, $urandom, $urandom};
			if (mode < 14)
				for (int k = 0; k < nsm_pkg::MAX_PATTERN; k++)
					pat[nsm_pkg::CHAR_W*k +: nsm_pkg::CHAR_W] = $urandom_range(1) ? CH_B : CH_A;
			else if (mode == 18)
				pat = '1;
			else if (mode == 19)
				pat = '0;
			wd = {$urandom, $urandom};
			wd[nsm_pkg::LEN_W-1:0] = nsm_pkg::LEN_W'(len_raw);
			write_reg(nsm_pkg::REG_PAT_LEN, wd);
			write_reg(nsm_pkg::REG_PAT_LOW, pat[nsm_pkg::REG_W-1:0]);
			write_reg(nsm_pkg::REG_PAT_HIGH, pat[nsm_pkg::PAT_W-1:nsm_pkg::REG_W]);
			if ($urandom_range(7) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
			repeat ($urandom_range(1, 4)) begin
				n = ($urandom_range(9) < 7) ? $urandom_range(1, 20) : $urandom_range(21, 60);
				fill_text(n);
				send_text();
				sent += n;
			end
			wait_idle();
		end
	endtask

	initial begin
		clear_text_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_pattern();
		test_overlap();
		test_short_text();
		test_length_clamp();
		test_output_hold();
		test_sender_pause();
		test_full_rate();
		test_random_texts();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
